// ===== sv/fsba_pkg.sv =====
// Package for the fit-strategy block allocator.
// Holds the shared codes, state type, defaults and the search control struct.
// No dependencies.
package fsba_pkg;

  // Default sizes of the free-size table.
  localparam int DEF_NUM_BLOCKS = 64;
  localparam int DEF_SIZE_BITS  = 16;

  // Configuration port layout and register indexes.
  localparam int CFG_DATA_BITS = 7;
  localparam logic REG_STRATEGY      = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [1:0] STRATEGY_RESET = 2'd0;
  localparam logic [6:0] BLOCKS_RESET   = 7'd64;

  // Selection rules; the unused fourth code behaves as first-fit.
  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_WORST = 2'd2;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WB
  } state_t;

  // Control from the sequencer to the candidate tracker.
  typedef struct packed {
    logic clear;
    logic consider;
  } pick_ctl_t;

endpackage

// ===== sv/fsba_mem.sv =====
// Free-size table of the allocator: one write port, one read port.
// Read data is registered and appears in the cycle after the read.
// Depends on nothing outside this file.
module fsba_mem #(
  parameter int NUM_BLOCKS = 64,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_BITS   = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_BITS-1:0]  waddr,
  input  logic [SIZE_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [IDX_BITS-1:0]  raddr,
  output logic [SIZE_BITS-1:0] rdata
);

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [SIZE_BITS-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fsba_pick.sv =====
// Candidate tracker: compares each entry read from the table with the request
// and keeps the block chosen so far under the selected rule.
// Depends on fsba_pkg.
module fsba_pick
  import fsba_pkg::*;
#(
  parameter int SIZE_BITS = 16,
  parameter int IDX_BITS  = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pick_ctl_t            ctl,
  input  logic [1:0]           strategy,
  input  logic [SIZE_BITS-1:0] req_size,
  input  logic [SIZE_BITS-1:0] rd_data,
  input  logic [IDX_BITS-1:0]  rd_idx,
  output logic                 found,
  output logic [IDX_BITS-1:0]  pick_idx,
  output logic [SIZE_BITS-1:0] pick_size
);

  logic                 found_r, found_nxt;
  logic [IDX_BITS-1:0]  idx_r, idx_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 fits;
  logic                 take;

  // Decide whether the entry just read replaces the current candidate.
  // Strict compares keep the lower index on a tie.
  always_comb begin
    fits = (rd_data >= req_size);
    case (strategy)
      STRAT_BEST:  take = fits && (!found_r || (rd_data < size_r));
      STRAT_WORST: take = fits && (!found_r || (rd_data > size_r));
      default:     take = fits && !found_r;
    endcase

    found_nxt = found_r;
    idx_nxt   = idx_r;
    size_nxt  = size_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.consider && take) begin
      found_nxt = 1'b1;
      idx_nxt   = rd_idx;
      size_nxt  = rd_data;
    end
  end

  // The found flag is control; the index and size are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    size_r <= size_nxt;
  end

  assign found     = found_r;
  assign pick_idx  = idx_r;
  assign pick_size = size_r;

endmodule

// ===== sv/fit_strategy_block_allocator.sv =====
// Top level of the fit-strategy block allocator: sequencer, configuration
// registers and result registers around the free-size table and tracker.
// Depends on fsba_pkg, fsba_mem and fsba_pick.

// A load transaction writes one table entry and gives its result strobe on
// the cycle after acceptance, with busy staying low, so loads can be issued
// every cycle. An allocate transaction reads the first L table entries, one
// per cycle from the single read port of the table, where L is blocks_in_use
// capped at NUM_BLOCKS; it then writes the chosen entry back and strobes its
// result. The strobe is registered from the write-back state, and busy is high
// from acceptance until that strobe. With L equal to zero the result strobes
// on the next cycle. The result is shown for one cycle only, since the
// receiver cannot stall. The table has no reset; every searched entry must be
// loaded before an allocation.
module fit_strategy_block_allocator
  import fsba_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS,
  localparam int IDX_BITS  = $clog2(NUM_BLOCKS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input transactions.
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_op,
  input  logic [IDX_BITS-1:0]      in_block_index,
  input  logic [SIZE_BITS-1:0]     in_size_value,
  // Results.
  output logic                     out_valid,
  output logic                     out_granted,
  output logic [IDX_BITS-1:0]      out_chosen_block,
  output logic [SIZE_BITS-1:0]     out_size_left,
  // Configuration writes.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);

  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0]  limit_r, limit_nxt;
  logic [CNT_BITS-1:0]  limit_cfg;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [1:0]           strategy_r;
  logic [6:0]           blocks_r;
  logic                 rd_valid_r;
  logic [IDX_BITS-1:0]  rd_idx_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r, out_granted_nxt;
  logic [IDX_BITS-1:0]  out_chosen_r, out_chosen_nxt;
  logic [SIZE_BITS-1:0] out_left_r, out_left_nxt;

  logic                 accept;
  logic                 idx_ok;
  logic                 mem_we;
  logic [IDX_BITS-1:0]  mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [SIZE_BITS-1:0] mem_rdata;
  logic [SIZE_BITS-1:0] size_after;
  pick_ctl_t            pick_ctl;
  logic                 pick_found;
  logic [IDX_BITS-1:0]  pick_idx;
  logic [SIZE_BITS-1:0] pick_size;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign idx_ok    = ({1'b0, in_block_index} < (IDX_BITS + 1)'(NUM_BLOCKS));

  // Number of entries searched, saturated at the table size.
  always_comb begin
    if (int'(blocks_r) > NUM_BLOCKS) begin
      limit_cfg = CNT_BITS'(NUM_BLOCKS);
    end else begin
      limit_cfg = CNT_BITS'(blocks_r);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r <= STRATEGY_RESET;
      blocks_r   <= BLOCKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STRATEGY:      strategy_r <= cfg_data[1:0];
        REG_BLOCKS_IN_USE: blocks_r   <= cfg_data[6:0];
        default:           ;
      endcase
    end
  end

  // Table access: loads and write-back share the write port.
  assign size_after = pick_size - req_r;
  assign mem_we     = (accept && (in_op == OP_LOAD) && idx_ok)
                   || ((state_r == ST_WB) && pick_found);
  assign mem_waddr  = (state_r == ST_WB) ? pick_idx : in_block_index;
  assign mem_wdata  = (state_r == ST_WB) ? size_after : in_size_value;
  assign mem_re     = (state_r == ST_SCAN);

  fsba_mem #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_BITS   (IDX_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cnt_r[IDX_BITS-1:0]),
    .rdata (mem_rdata)
  );

  // The tracker sees each entry the cycle after its read is issued.
  assign pick_ctl.clear    = accept;
  assign pick_ctl.consider = rd_valid_r;

  fsba_pick #(
    .SIZE_BITS (SIZE_BITS),
    .IDX_BITS  (IDX_BITS)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pick_ctl),
    .strategy  (strategy_r),
    .req_size  (req_r),
    .rd_data   (mem_rdata),
    .rd_idx    (rd_idx_r),
    .found     (pick_found),
    .pick_idx  (pick_idx),
    .pick_size (pick_size)
  );

  // Sequencer and result formation.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    limit_nxt       = limit_r;
    req_nxt         = req_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = 1'b0;
    out_chosen_nxt  = '0;
    out_left_nxt    = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_LOAD) begin
            out_valid_nxt = 1'b1;
          end else if (limit_cfg == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            req_nxt   = in_size_value;
            limit_nxt = limit_cfg;
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if ((cnt_r + 1'b1) == limit_r) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        out_valid_nxt = 1'b1;
        if (pick_found) begin
          out_granted_nxt = 1'b1;
          out_chosen_nxt  = pick_idx;
          out_left_nxt    = size_after;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_valid_r  <= mem_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    limit_r       <= limit_nxt;
    req_r         <= req_nxt;
    rd_idx_r      <= cnt_r[IDX_BITS-1:0];
    out_granted_r <= out_granted_nxt;
    out_chosen_r  <= out_chosen_nxt;
    out_left_r    <= out_left_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_block = out_chosen_r;
  assign out_size_left    = out_left_r;

endmodule

// ===== sv/fsba_checker.sv =====
// Port-level checks for the fit-strategy block allocator, bound to the top.
// Depends on fsba_pkg and fit_strategy_block_allocator.
module fsba_checker
  import fsba_pkg::*;
#(
  parameter int SIZE_BITS = 16,
  parameter int IDX_BITS  = 6
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 in_op,
  input logic                 out_valid,
  input logic                 out_granted,
  input logic [IDX_BITS-1:0]  out_chosen_block,
  input logic [SIZE_BITS-1:0] out_size_left
);

  // A load transaction is answered on the next cycle, never with a grant.
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_LOAD)) |=> (out_valid && !out_granted))
    else $error("load transaction not answered on the next cycle");

  // A refused result carries zero index and zero size.
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> ((out_chosen_block == '0) && (out_size_left == '0)))
    else $error("refused result carries a non-zero payload");

  // A result strobe always coincides with the block being free again.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Busy only rises on an accepted transaction.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy raised without an accepted transaction");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind fit_strategy_block_allocator fsba_checker #(
  .SIZE_BITS (SIZE_BITS),
  .IDX_BITS  (IDX_BITS)
) u_fsba_checker (.*);
